/* rtl/dsct_pkg.sv */
package dsct_pkg;

    localparam int unsigned DAYS_W = 17;
    localparam int unsigned TOD_W  = 24;
    localparam int unsigned CS_W   = 40;

    localparam logic [11:0] FILE_TYPE_RESET = 12'hFE4;
    localparam logic [11:0] LOAD_PREFIX     = 12'hFFF;

    // 1980 - 1900, and the leap years 1904..1976
    localparam logic [DAYS_W-1:0] BASE_YEAR_OFS  = 17'd80;
    localparam logic [DAYS_W-1:0] LEAPS_TO_BASE  = 17'd19;
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR  = 17'd365;
    // 2100 is the only year in range that is a multiple of four but not leap
    localparam logic [6:0]        CENTURY_YEAR   = 7'd120;

    localparam logic [TOD_W-1:0]  CS_PER_HOUR    = 24'd360000;
    localparam logic [TOD_W-1:0]  CS_PER_MIN     = 24'd6000;
    localparam logic [TOD_W-1:0]  CS_PER_2SEC    = 24'd200;
    localparam logic [23:0]       CS_PER_DAY     = 24'd8640000;

    localparam logic [3:0] MONTH_MARCH = 4'd3;
    localparam logic [3:0] MONTH_DEC   = 4'd12;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
        logic              dflt;
    } conv_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] r;
        case (month)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/dsct_if.sv */
interface dsct_stamp_if;
    logic        valid;
    logic        ready;
    logic [15:0] dos_time;
    logic [15:0] dos_date;

    modport source(output valid, output dos_time, output dos_date, input ready);
    modport sink(input valid, input dos_time, input dos_date, output ready);
endinterface

interface dsct_time_if;
    logic        valid;
    logic        ready;
    logic [31:0] load_word;
    logic [31:0] exec_word;
    logic        used_default;

    modport source(output valid, output load_word, output exec_word,
                   output used_default, input ready);
    modport sink(input valid, input load_word, input exec_word,
                 input used_default, output ready);
endinterface

/* rtl/dos_stamp_to_centisec_time.sv */
// FAT date/time stamp to centiseconds since 1 January 1900.
// stamp: input channel, one beat carries a FAT time word and a FAT date word.
// result: output channel, one beat per stamp carrying the load word (0xFFF prefix,
//   file type, time bits 39:32) and the exec word (time bits 31:0), plus a flag
//   that is set when a zero stamp or an invalid month forced the time to zero.
// cfg_we/cfg_wdata: writes the 12-bit file type; only write while the block is idle.
// Throughput: one stamp per cycle while the result is not stalled.
// The input register feeds the field decode and day count, a middle register
//   holds days and time of day, and the single 17 x 24 bit multiply by
//   centiseconds per day sits before the result register.
// Each stage advances whenever the stage after it is empty or moving, so the
//   block keeps taking stamps while a finished result waits, until all three
//   registers are full; a stalled result beat holds its payload.
// Reset: clears all stages to empty and sets the file type to 0xFE4.
module dos_stamp_to_centisec_time (
    input  logic                clk,
    input  logic                rst_n,
    dsct_stamp_if.sink          stamp,
    dsct_time_if.source         result,
    input  logic                cfg_we,
    input  logic [11:0]         cfg_wdata
);

    logic                           in_valid_reg;
    logic [15:0]                    in_time_reg;
    logic [15:0]                    in_date_reg;
    logic                           mid_valid_reg;
    dsct_pkg::conv_t                mid_reg;
    logic                           out_valid_reg;
    logic [dsct_pkg::CS_W-1:0]      out_cs_reg;
    logic                           out_dflt_reg;
    logic [11:0]                    file_type_reg;

    dsct_pkg::conv_t                conv;
    logic [dsct_pkg::CS_W-1:0]      cs_next;
    logic                           adv_out;
    logic                           adv_mid;
    logic                           adv_in;

    dsct_convert u_convert (
        .dos_time (in_time_reg),
        .dos_date (in_date_reg),
        .conv     (conv)
    );

    assign adv_out = !out_valid_reg || result.ready;
    assign adv_mid = !mid_valid_reg || adv_out;
    assign adv_in  = !in_valid_reg  || adv_mid;

    assign stamp.ready = adv_in;

    assign cs_next = {23'd0, mid_reg.days} * {16'd0, dsct_pkg::CS_PER_DAY}
                   + {16'd0, mid_reg.tod};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            file_type_reg <= dsct_pkg::FILE_TYPE_RESET;
        end
        else
        begin
            if (adv_in)
                in_valid_reg <= stamp.valid;
            if (adv_mid)
                mid_valid_reg <= in_valid_reg;
            if (adv_out)
                out_valid_reg <= mid_valid_reg;
            if (cfg_we)
                file_type_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && stamp.valid)
        begin
            in_time_reg <= stamp.dos_time;
            in_date_reg <= stamp.dos_date;
        end
        if (adv_mid && in_valid_reg)
            mid_reg <= conv;
        if (adv_out && mid_valid_reg)
        begin
            out_cs_reg   <= cs_next;
            out_dflt_reg <= mid_reg.dflt;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.load_word    = {dsct_pkg::LOAD_PREFIX, file_type_reg, out_cs_reg[39:32]};
    assign result.exec_word    = out_cs_reg[31:0];
    assign result.used_default = out_dflt_reg;

    // a forced default carries a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dflt_reg) |-> (out_cs_reg == '0))
        else $error("default result with non-zero time");

    // an empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> stamp.ready)
        else $error("input stalled with empty result register");

    // a held middle stage is not lost while the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && out_valid_reg && !result.ready) |=> mid_valid_reg)
        else $error("middle stage dropped during stall");

    // an accepted stamp reaches the middle stage whenever the middle stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !mid_valid_reg) |=> mid_valid_reg)
        else $error("stamp did not advance into empty middle stage");

endmodule

/* rtl/dsct_convert.sv */
module dsct_convert (
    input  logic [15:0]    dos_time,
    input  logic [15:0]    dos_date,
    output dsct_pkg::conv_t conv
);

    logic [6:0]                     year_ofs;
    logic [3:0]                     month;
    logic [4:0]                     day;
    logic [4:0]                     hour;
    logic [5:0]                     minute;
    logic [4:0]                     sec2;
    logic [dsct_pkg::DAYS_W-1:0]    year_days;
    logic [dsct_pkg::DAYS_W-1:0]    leap_days;
    logic [dsct_pkg::DAYS_W-1:0]    day_ofs;
    logic                           leap_year;
    logic                           leap_adj;
    logic                           bad;
    logic [7:0]                     year_ofs_rnd;

    always_comb
    begin
        year_ofs = dos_date[15:9];
        month    = dos_date[8:5];
        day      = dos_date[4:0];
        hour     = dos_time[15:11];
        minute   = dos_time[10:5];
        sec2     = dos_time[4:0];

        bad = ((dos_time == 16'd0) && (dos_date == 16'd0))
            || (month == 4'd0) || (month > dsct_pkg::MONTH_DEC);

        year_days = (dsct_pkg::BASE_YEAR_OFS + {10'd0, year_ofs}) * dsct_pkg::DAYS_PER_YEAR;

        // leap years from 1980 up to the year before this one
        year_ofs_rnd = {1'b0, year_ofs} + 8'd3;
        leap_days    = dsct_pkg::LEAPS_TO_BASE + {11'd0, year_ofs_rnd[7:2]}
                     - {16'd0, (year_ofs > dsct_pkg::CENTURY_YEAR)};

        leap_year = (year_ofs[1:0] == 2'd0) && (year_ofs != dsct_pkg::CENTURY_YEAR);
        leap_adj  = leap_year && (month >= dsct_pkg::MONTH_MARCH);

        // day zero counts as the first of the month
        day_ofs = (day == 5'd0) ? '0 : {12'd0, day - 5'd1};

        if (bad)
        begin
            conv.days = '0;
            conv.tod  = '0;
        end
        else
        begin
            conv.days = year_days + leap_days
                      + {8'd0, dsct_pkg::days_before_month(month)}
                      + {16'd0, leap_adj} + day_ofs;
            conv.tod  = {19'd0, hour} * dsct_pkg::CS_PER_HOUR
                      + {18'd0, minute} * dsct_pkg::CS_PER_MIN
                      + {19'd0, sec2} * dsct_pkg::CS_PER_2SEC;
        end
        conv.dflt = bad;
    end

endmodule
